// ----- rtl/prf_pkg.sv -----
// Package for the Pollard-rho factor unit: state codes, result codes, limits.
// No dependencies.
`timescale 1ns / 1ps
package prf_pkg;

  localparam int unsigned EXP_LIMIT  = 26;
  localparam int unsigned STEP_BITS  = 27;
  localparam int unsigned DVD_BITS   = 64;
  localparam int unsigned FIELD_BITS = 64;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_FAILED = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  localparam logic [3:0] REG_LOG_BASE = 4'd0;
  localparam logic [3:0] REG_ATT_CAP  = 4'd1;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_INC      = 10'b0000000010,
    S_START    = 10'b0000000100,
    S_MUL      = 10'b0000001000,
    S_DIFF     = 10'b0000010000,
    S_GCD_TWO  = 10'b0000100000,
    S_GCD      = 10'b0001000000,
    S_NEXT     = 10'b0010000000,
    S_QUOT     = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

endpackage

// ----- rtl/prf_div.sv -----
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on prf_pkg.
`timescale 1ns / 1ps
module prf_div
  import prf_pkg::*;
#(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DVD_BITS-1:0]   dividend,
  input  logic [WORD_BITS-1:0]  divisor,
  output logic                  done,
  output logic [DVD_BITS-1:0]   quotient,
  output logic [WORD_BITS-1:0]  remainder
);

  localparam int unsigned CNT_BITS = $clog2(DVD_BITS + 1);

  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  logic [DVD_BITS-1:0]  dvd;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;

  assign trial = {remainder, dvd[DVD_BITS-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CNT_BITS'(DVD_BITS);
        dvd       <= dividend;
        remainder <= '0;
        quotient  <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          remainder <= diff[WORD_BITS-1:0];
          quotient  <= {quotient[DVD_BITS-2:0], 1'b1};
        end else begin
          remainder <= trial[WORD_BITS-1:0];
          quotient  <= {quotient[DVD_BITS-2:0], 1'b0};
        end
        dvd <= {dvd[DVD_BITS-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/pollard_rho_factor_u64_unit.sv -----
// Pollard-rho factor unit, top level: sequencer, modular square-add, binary gcd.
// Depends on prf_pkg and prf_div.
`timescale 1ns / 1ps
// One Pollard-rho attempt (Brent saving of the comparison point) per input
// transaction; one result transaction per input. The unit takes one item at a
// time and drops s_tready while it works. Each item first runs two start
// reductions through the shared divider, then per rho step (popcount-free) a
// double-and-add multiply, a difference, the binary gcd, which takes one shift
// or one subtract per cycle, and a step update; a found factor adds a divider
// pass for the cofactor.
// Steps run up to 2^(min(attempt,attempt_cap)+log_base_steps) - 1, exponent
// capped at 26. The serial multiply and gcd loops dominate the run time.
// Out-of-range composites answer directly with range status. Configuration
// writes are always taken (cfg_ready is high).
module pollard_rho_factor_u64_unit
  import prf_pkg::*;
#(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic          clk,
  input  logic          rst,
  // composite[63:0], start_random[127:64], offset_random[135:128],
  // attempt[138:136], zero pad
  input  logic [143:0]  s_tdata,
  input  logic          s_tvalid,
  output logic          s_tready,
  // factor[63:0], zero pad
  output logic [71:0]   m_tdata,
  // status[1:0]
  output logic [1:0]    m_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [3:0]    cfg_index,
  input  logic [7:0]    cfg_data
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned TW = $clog2(W) + 1;

  state_t state;

  // configuration
  logic [4:0] log_base_steps;
  logic [3:0] attempt_cap;

  // item state
  logic [W-1:0]          modulus;
  logic [W-1:0]          walker;
  logic [W-1:0]          saved_point;
  logic [W-1:0]          increment;
  logic [W-1:0]          mul_addend;
  logic [W-1:0]          mul_multiplier;
  logic [W-1:0]          mul_sum;
  logic [W-1:0]          gcd_left;
  logic [W-1:0]          gcd_right;
  logic [TW-1:0]         gcd_twos;
  logic [W-1:0]          gcd_value;
  logic [STEP_BITS-1:0]  step_index;
  logic [STEP_BITS-1:0]  step_limit;
  logic [63:0]           start_word;
  logic [63:0]           res_factor;
  logic [1:0]            res_status;

  // divider
  logic                  div_go;
  logic [DVD_BITS-1:0]   div_a;
  logic [W-1:0]          div_b;
  logic                  div_done;
  logic [DVD_BITS-1:0]   div_q;
  logic [W-1:0]          div_r;

  prf_div #(.WORD_BITS(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // input decode
  logic [W-1:0] in_n;
  logic         in_bad;
  logic [3:0]   att_min;
  logic [5:0]   expo_sum;
  logic [4:0]   expo;

  assign in_n     = s_tdata[W-1:0];
  assign in_bad   = (in_n[W-1:1] == '0) || (in_n[W-1] && (in_n[W-2:0] != '0));
  assign att_min  = ({1'b0, s_tdata[138:136]} < attempt_cap) ?
                    {1'b0, s_tdata[138:136]} : attempt_cap;
  assign expo_sum = {2'b00, att_min} + {1'b0, log_base_steps};
  assign expo     = (expo_sum > 6'(EXP_LIMIT)) ? 5'(EXP_LIMIT) : expo_sum[4:0];

  // modular double-and-add datapath
  logic [W-1:0] sum_add, sum_red, dbl_add, dbl_red;
  assign sum_add = mul_sum + mul_addend;
  assign sum_red = (sum_add >= modulus) ? sum_add - modulus : sum_add;
  assign dbl_add = {mul_addend[W-2:0], 1'b0};
  assign dbl_red = (dbl_add >= modulus) ? dbl_add - modulus : dbl_add;

  // (x - y) mod n
  logic [W-1:0] diff_raw, diff_val;
  assign diff_raw = walker - saved_point;
  assign diff_val = (walker < saved_point) ? diff_raw + modulus : diff_raw;

  logic [STEP_BITS-1:0] step_inc;
  logic                 step_pow2;
  assign step_inc  = step_index + 1'b1;
  assign step_pow2 = (step_index & (step_index - 1'b1)) == '0;

  logic [W-1:0] quot_w;
  assign quot_w = div_q[W-1:0];

  // divider kick: start reductions, then the cofactor division
  logic div_go_next;
  logic m_tvalid_next;
  assign div_go_next = ((state == S_IDLE) && s_tvalid && !in_bad) ||
                       ((state == S_INC) && div_done) ||
                       ((state == S_NEXT) && (gcd_value > W'(1)) &&
                        (gcd_value < modulus));
  // result register: loads from S_DONE, holds until taken
  assign m_tvalid_next = ((state == S_DONE) && (!m_tvalid || m_tready)) ||
                         (m_tvalid && !m_tready);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      div_go   <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
      div_go   <= div_go_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      log_base_steps <= 5'd18;
      attempt_cap    <= 4'd5;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LOG_BASE: log_base_steps <= cfg_data[4:0];
          REG_ATT_CAP:  attempt_cap    <= cfg_data[3:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            modulus    <= in_n;
            start_word <= s_tdata[127:64];
            step_limit <= STEP_BITS'(1) << expo;
            step_index <= STEP_BITS'(1);
            if (in_bad) begin
              res_factor <= 64'd1;
              res_status <= ST_RANGE;
              state      <= S_DONE;
            end else begin
              div_a  <= DVD_BITS'(s_tdata[135:128]);
              div_b  <= in_n - 1'b1;
              state  <= S_INC;
            end
          end
        end
        S_INC: begin
          if (div_done) begin
            increment <= div_r;
            div_a     <= start_word;
            state     <= S_START;
          end
        end
        S_START: begin
          if (div_done) begin
            walker      <= div_r + 1'b1;
            saved_point <= div_r + 1'b1;
            if (step_limit == STEP_BITS'(1)) begin
              res_factor <= 64'd1;
              res_status <= ST_FAILED;
              state      <= S_DONE;
            end else begin
              mul_addend     <= div_r + 1'b1;
              mul_multiplier <= div_r + 1'b1;
              mul_sum        <= increment;
              state          <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_multiplier == '0) begin
            walker <= mul_sum;
            state  <= S_DIFF;
          end else begin
            if (mul_multiplier[0]) mul_sum <= sum_red;
            mul_addend     <= dbl_red;
            mul_multiplier <= mul_multiplier >> 1;
          end
        end
        S_DIFF: begin
          gcd_left  <= diff_val;
          gcd_right <= modulus;
          gcd_twos  <= '0;
          if (diff_val == '0) begin
            gcd_value <= modulus;
            state     <= S_NEXT;
          end else begin
            state <= S_GCD_TWO;
          end
        end
        S_GCD_TWO: begin
          // strip common factors of two
          if (!gcd_left[0] && !gcd_right[0]) begin
            gcd_left  <= gcd_left >> 1;
            gcd_right <= gcd_right >> 1;
            gcd_twos  <= gcd_twos + 1'b1;
          end else begin
            state <= S_GCD;
          end
        end
        S_GCD: begin
          priority if (!gcd_left[0]) begin
            gcd_left <= gcd_left >> 1;
          end else if (!gcd_right[0]) begin
            gcd_right <= gcd_right >> 1;
          end else if (gcd_left > gcd_right) begin
            gcd_left <= gcd_left - gcd_right;
          end else if (gcd_right > gcd_left) begin
            gcd_right <= gcd_right - gcd_left;
          end else begin
            gcd_value <= gcd_left << gcd_twos[TW-2:0];
            state     <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (gcd_value != W'(1)) begin
            if (gcd_value > W'(1) && gcd_value < modulus) begin
              div_a  <= DVD_BITS'(modulus);
              div_b  <= gcd_value;
              state  <= S_QUOT;
            end else begin
              res_factor <= 64'd1;
              res_status <= ST_FAILED;
              state      <= S_DONE;
            end
          end else begin
            if (step_pow2) saved_point <= walker;
            step_index <= step_inc;
            if (step_inc < step_limit) begin
              mul_addend     <= walker;
              mul_multiplier <= walker;
              mul_sum        <= increment;
              state          <= S_MUL;
            end else begin
              res_factor <= 64'd1;
              res_status <= ST_FAILED;
              state      <= S_DONE;
            end
          end
        end
        S_QUOT: begin
          if (div_done) begin
            res_factor <= (quot_w < gcd_value) ? FIELD_BITS'(quot_w) : FIELD_BITS'(gcd_value);
            res_status <= ST_FOUND;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {8'd0, res_factor};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
